[design/dpr_pkg.sv]
`default_nettype none
package dpr_pkg;
    localparam logic [2:0] IDX_FOCAL_BASELINE = 3'd0;
    localparam logic [2:0] IDX_CENTER_COL     = 3'd1;
    localparam logic [2:0] IDX_CENTER_ROW     = 3'd2;
    localparam logic [2:0] IDX_RECIP_X        = 3'd3;
    localparam logic [2:0] IDX_RECIP_Y        = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_MUL  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic        pvalid;
        logic [9:0]  disp;
        logic [15:0] ref_depth;
        logic        neg_x;
        logic [15:0] mag_x;
        logic        neg_y;
        logic [15:0] mag_y;
        logic        fend;
    } t_item;
endpackage
`default_nettype wire

[design/disparity_to_point_reprojection_top.sv]
// Channel  | Valid      | Stall      | Payload
// input    | i_valid    | o_stall    | i_disparity_q4 .. i_frame_end
// result   | o_valid    | i_stall    | o_point_valid .. o_ref_valid_count
// Config   | i_cfg_we   | none       | i_cfg_index, i_cfg_data
// In the back part an item passes one step to take it from the queue, 24 steps
// of the restoring divider for z, three multiply steps and one output step.
// A two-entry queue lets the front accept up to two items while the back part
// is busy. Reset is synchronous and clears control, statistics and the
// configuration registers. The result register holds while o_valid and i_stall
// are high; the back part then waits.
`default_nettype none
module disparity_to_point_reprojection_top
    import dpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [10:0] i_disparity_q4,
    input  wire logic [15:0] i_ref_depth,
    input  wire logic [11:0] i_pixel_col,
    input  wire logic [11:0] i_pixel_row,
    input  wire logic        i_frame_end,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_point_valid,
    output logic [31:0]      o_x_mm,
    output logic [31:0]      o_y_mm,
    output logic [23:0]      o_z_mm,
    output logic [15:0]      o_depth_sat,
    output logic             o_compare_valid,
    output logic [23:0]      o_abs_error_mm,
    output logic [39:0]      o_frame_error_sum,
    output logic [24:0]      o_frame_compare_count,
    output logic [23:0]      o_frame_err_max,
    output logic [23:0]      o_session_max_error,
    output logic [24:0]      o_ref_valid_count
);
    logic [23:0] r_fb, r_rx, r_ry;
    logic [15:0] r_cc, r_cr;
    logic  q_valid, q_pop;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb <= '0; r_rx <= '0; r_ry <= '0; r_cc <= '0; r_cr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                IDX_FOCAL_BASELINE: r_fb <= i_cfg_data;
                IDX_CENTER_COL:     r_cc <= i_cfg_data[15:0];
                IDX_CENTER_ROW:     r_cr <= i_cfg_data[15:0];
                IDX_RECIP_X:        r_rx <= i_cfg_data;
                IDX_RECIP_Y:        r_ry <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_disparity_q4(i_disparity_q4), .i_ref_depth(i_ref_depth),
        .i_pixel_col(i_pixel_col), .i_pixel_row(i_pixel_row), .i_frame_end(i_frame_end),
        .i_center_col_q4(r_cc), .i_center_row_q4(r_cr),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    dpr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_item(q_item), .i_focal_baseline_q4(r_fb), .i_recip_x(r_rx), .i_recip_y(r_ry),
        .o_valid(o_valid), .i_stall(i_stall), .o_point_valid(o_point_valid),
        .o_x_mm(o_x_mm), .o_y_mm(o_y_mm), .o_z_mm(o_z_mm), .o_depth_sat(o_depth_sat),
        .o_compare_valid(o_compare_valid), .o_abs_error_mm(o_abs_error_mm),
        .o_frame_error_sum(o_frame_error_sum), .o_frame_compare_count(o_frame_compare_count),
        .o_frame_err_max(o_frame_err_max), .o_session_max_error(o_session_max_error),
        .o_ref_valid_count(o_ref_valid_count)
    );
endmodule
`default_nettype wire

[design/dpr_front.sv]
`default_nettype none
module dpr_front
    import dpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [10:0] i_disparity_q4,
    input  wire logic [15:0] i_ref_depth,
    input  wire logic [11:0] i_pixel_col,
    input  wire logic [11:0] i_pixel_row,
    input  wire logic        i_frame_end,
    input  wire logic [15:0] i_center_col_q4,
    input  wire logic [15:0] i_center_row_q4,
    output logic             o_q_valid,
    input  wire logic        i_q_pop,
    output t_item            o_q_item
);
    // Two-entry queue between classification and the arithmetic back part.
    t_item r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item n_item;
    logic [15:0] p16c, p16r;
    logic push;

    assign o_stall  = (r_cnt == 2'd2);
    assign push     = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_comb begin
        p16c = {i_pixel_col, 4'd0};
        p16r = {i_pixel_row, 4'd0};
        n_item.pvalid    = !i_disparity_q4[10] && (i_disparity_q4 != 11'd0);
        n_item.disp      = i_disparity_q4[9:0];
        n_item.ref_depth = i_ref_depth;
        n_item.neg_x     = i_center_col_q4 > p16c;
        n_item.mag_x     = n_item.neg_x ? i_center_col_q4 - p16c : p16c - i_center_col_q4;
        n_item.neg_y     = i_center_row_q4 > p16r;
        n_item.mag_y     = n_item.neg_y ? i_center_row_q4 - p16r : p16r - i_center_row_q4;
        n_item.fend      = i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

[design/dpr_back.sv]
`default_nettype none
module dpr_back
    import dpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    output logic             o_q_pop,
    input  wire t_item       i_q_item,
    input  wire logic [23:0] i_focal_baseline_q4,
    input  wire logic [23:0] i_recip_x,
    input  wire logic [23:0] i_recip_y,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_point_valid,
    output logic [31:0]      o_x_mm,
    output logic [31:0]      o_y_mm,
    output logic [23:0]      o_z_mm,
    output logic [15:0]      o_depth_sat,
    output logic             o_compare_valid,
    output logic [23:0]      o_abs_error_mm,
    output logic [39:0]      o_frame_error_sum,
    output logic [24:0]      o_frame_compare_count,
    output logic [23:0]      o_frame_err_max,
    output logic [23:0]      o_session_max_error,
    output logic [24:0]      o_ref_valid_count
);
    localparam logic [24:0] CNT_MAX = '1;
    localparam logic [39:0] SUM_MAX = '1;

    t_state r_state, n_state;
    t_item  r_it;
    // Restoring divider: remainder, quotient shifted in, step counter.
    logic [23:0] r_rem, r_quo;
    logic [4:0]  r_step;
    // Products: mag*z (40 b) then times recip in two 12-bit halves.
    logic [1:0]  r_mstep;
    logic [39:0] r_px, r_py;
    logic [63:0] r_accx, r_accy;
    logic [39:0] r_sum;
    logic [24:0] r_ccnt, r_rcnt;
    logic [23:0] r_fmax, r_smax;
    logic        r_ov;

    logic [24:0] trial;
    logic [23:0] err;
    logic [40:0] sum_w;
    logic        cv, load, done;

    assign trial = {r_rem, r_quo[23]} - {15'd0, r_it.disp};
    assign cv    = r_it.pvalid && (r_it.ref_depth != 16'd0);
    assign err   = (r_quo > {8'd0, r_it.ref_depth}) ? r_quo - {8'd0, r_it.ref_depth}
                                                    : {8'd0, r_it.ref_depth} - r_quo;
    assign sum_w = {1'b0, r_sum} + {17'd0, err};
    assign load  = (r_state == ST_IDLE) && i_q_valid;
    assign done  = (r_state == ST_OUT) && (!r_ov || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_DIV;
            ST_DIV:  if (r_step == 5'd23) n_state = ST_MUL;
            ST_MUL:  if (r_mstep == 2'd2) n_state = ST_OUT;
            ST_OUT:  if (done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = load;
    end

    function automatic logic [31:0] fin(input logic neg, input logic [63:0] p);
        logic [36:0] q;
        begin
            q = p[63:28];
            if (neg) begin
                q = q + {36'd0, (p[27:0] != 28'd0)};
                if (q > 37'h80000000) q = 37'h80000000;
                fin = 32'd0 - q[31:0];
            end else begin
                if (q > 37'h7FFFFFFF) q = 37'h7FFFFFFF;
                fin = q[31:0];
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_it <= i_q_item; r_rem <= '0; r_quo <= i_focal_baseline_q4; r_step <= '0;
            r_mstep <= '0;
        end
        if (r_state == ST_DIV) begin
            r_step <= r_step + 5'd1;
            if (!trial[24]) begin
                r_rem <= trial[23:0]; r_quo <= {r_quo[22:0], 1'b1};
            end else begin
                r_rem <= {r_rem[22:0], r_quo[23]}; r_quo <= {r_quo[22:0], 1'b0};
            end
        end
        if (r_state == ST_MUL) begin
            r_mstep <= r_mstep + 2'd1;
            case (r_mstep)
                2'd0: begin
                    r_px <= r_it.mag_x * r_quo; r_py <= r_it.mag_y * r_quo;
                end
                2'd1: begin
                    r_accx <= {24'd0, r_px} * {52'd0, i_recip_x[11:0]};
                    r_accy <= {24'd0, r_py} * {52'd0, i_recip_y[11:0]};
                end
                default: begin
                    r_accx <= r_accx + (({24'd0, r_px} * {52'd0, i_recip_x[23:12]}) << 12);
                    r_accy <= r_accy + (({24'd0, r_py} * {52'd0, i_recip_y[23:12]}) << 12);
                end
            endcase
        end
        if (r_state == ST_OUT && done) begin
            o_point_valid   <= r_it.pvalid;
            o_x_mm          <= r_it.pvalid ? fin(r_it.neg_x, r_accx) : 32'd0;
            o_y_mm          <= r_it.pvalid ? fin(r_it.neg_y, r_accy) : 32'd0;
            o_z_mm          <= r_it.pvalid ? r_quo : 24'd0;
            o_depth_sat     <= !r_it.pvalid ? 16'd0 : (r_quo[23:16] != 8'd0) ? 16'hFFFF
                               : r_quo[15:0];
            o_compare_valid <= cv;
            o_abs_error_mm  <= cv ? err : 24'd0;
            o_frame_error_sum     <= cv ? (sum_w[40] ? SUM_MAX : sum_w[39:0]) : r_sum;
            o_frame_compare_count <= (cv && r_ccnt != CNT_MAX) ? r_ccnt + 25'd1 : r_ccnt;
            o_frame_err_max       <= (cv && err > r_fmax) ? err : r_fmax;
            o_session_max_error   <= (cv && err > r_smax) ? err : r_smax;
            o_ref_valid_count     <= (r_it.ref_depth != 16'd0 && r_rcnt != CNT_MAX)
                                     ? r_rcnt + 25'd1 : r_rcnt;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ov <= 1'b0;
            r_sum <= '0; r_ccnt <= '0; r_fmax <= '0; r_smax <= '0; r_rcnt <= '0;
        end else begin
            r_state <= n_state;
            if (done) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (done) begin
                if (cv && err > r_smax) r_smax <= err;
                if (r_it.fend) begin
                    r_sum <= '0; r_ccnt <= '0; r_fmax <= '0; r_rcnt <= '0;
                end else begin
                    if (cv) begin
                        r_sum <= sum_w[40] ? SUM_MAX : sum_w[39:0];
                        if (r_ccnt != CNT_MAX) r_ccnt <= r_ccnt + 25'd1;
                        if (err > r_fmax) r_fmax <= err;
                    end
                    if (r_it.ref_depth != 16'd0 && r_rcnt != CNT_MAX)
                        r_rcnt <= r_rcnt + 25'd1;
                end
            end
        end
    end

    assign o_valid = r_ov;
endmodule
`default_nettype wire

[design/dpr_checker.sv]
`default_nettype none
module dpr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_point_valid,
    input wire logic        o_compare_valid,
    input wire logic [23:0] o_abs_error_mm,
    input wire logic [23:0] o_frame_err_max,
    input wire logic [23:0] o_session_max_error,
    input wire logic [15:0] o_depth_sat,
    input wire logic [31:0] o_x_mm
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_mm))
        else $error("stalled result changed");
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_valid |-> o_point_valid)
        else $error("compare without point");
    a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_session_max_error >= o_frame_err_max
                    && o_frame_err_max >= o_abs_error_mm)
        else $error("maximum ordering broken");
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> o_depth_sat == 16'd0 && o_x_mm == 32'd0)
        else $error("invalid point not zero");
endmodule

bind disparity_to_point_reprojection_top dpr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_point_valid(o_point_valid), .o_compare_valid(o_compare_valid),
    .o_abs_error_mm(o_abs_error_mm), .o_frame_err_max(o_frame_err_max),
    .o_session_max_error(o_session_max_error), .o_depth_sat(o_depth_sat), .o_x_mm(o_x_mm)
);
`default_nettype wire
